### rtl/mnpt_pkg.sv
package mnpt_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int IDX_W = $clog2(PENDING_DEPTH);
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  localparam int MODE_W  = 2;
  localparam int KEY_W   = 7;
  localparam int VEL_W   = 7;
  localparam int TICK_W  = 32;
  localparam int NUM_W   = 32;

  localparam logic [MODE_W-1:0] MODE_ON  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL = 2'd2;

  localparam logic KIND_NOTE = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
    logic [TICK_W-1:0] start;
    logic [NUM_W-1:0]  number;
  } pend_entry_t;

endpackage

### rtl/mnpt_evt_if.sv
interface mnpt_evt_if
  import mnpt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  logic [VEL_W-1:0]  velocity;
  logic [TICK_W-1:0] tick;

  modport source (output valid, mode, key, velocity, tick, input ready);
  modport sink   (input valid, mode, key, velocity, tick, output ready);
endinterface

### rtl/mnpt_note_if.sv
interface mnpt_note_if
  import mnpt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NUM_W-1:0]  note_number;
  logic [KEY_W-1:0]  note_key;
  logic [VEL_W-1:0]  note_velocity;
  logic [TICK_W-1:0] start_time;
  logic [TICK_W-1:0] end_time;
  logic              last;
  logic              polyphonic;
  logic [TICK_W-1:0] track_start;
  logic              track_started;

  modport source (output valid, kind, note_number, note_key, note_velocity, start_time,
                  end_time, last, polyphonic, track_start, track_started, input ready);
  modport sink   (input valid, kind, note_number, note_key, note_velocity, start_time,
                  end_time, last, polyphonic, track_start, track_started, output ready);
endinterface

### rtl/midi_note_pairing_tracker_core.sv
// Channel  Dir  Word
// evt      in   mode, key, velocity, tick
// res      out  finished note or dropped open, with last and track flags
//
// One word in at a time; ready only while idle. For a word, one key comparator walks
// the list twice, first to count matches, then to emit and compact; a dropped open
// then passes through the drop state before the core is idle again.
// Emission stalls while the output register is full and not taken.
// Synchronous reset empties the list and clears the flags and the sequence count.
module midi_note_pairing_tracker_core
  import mnpt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  mnpt_evt_if.sink      evt,
  mnpt_note_if.source   res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_COUNT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DROP  = 4'b1000
  } state_t;

  state_t state;

  pend_entry_t pend [PENDING_DEPTH];

  logic [CNT_W-1:0]  count;
  logic [NUM_W-1:0]  opened;
  logic              overlap;
  logic [TICK_W-1:0] first_tick;
  logic              first_valid;

  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [VEL_W-1:0]  vel_q;
  logic [TICK_W-1:0] tick_q;

  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  wr;
  logic [CNT_W-1:0]  match_cnt;
  logic [CNT_W-1:0]  rm;
  logic              full_q;

  logic              out_valid;
  logic              o_kind;
  logic [NUM_W-1:0]  o_number;
  logic [KEY_W-1:0]  o_key;
  logic [VEL_W-1:0]  o_vel;
  logic [TICK_W-1:0] o_start;
  logic [TICK_W-1:0] o_end;
  logic              o_last;
  logic              o_poly;
  logic [TICK_W-1:0] o_track;
  logic              o_started;

  pend_entry_t       cur;
  logic              scan_more;
  logic              key_hit;
  logic              hit;
  logic              can_push;
  logic              take;
  logic              emit_note;
  logic              emit_drop;
  logic              copy_we;
  logic              scan_step;
  logic              scan_done;
  logic              append_we;
  logic [CNT_W-1:0]  rest;
  logic [CNT_W-1:0]  rm_init;
  logic              full_next;

  always_comb begin
    cur       = pend[idx[IDX_W-1:0]];
    scan_more = idx < count;
    key_hit   = cur.key == key_q;
    hit       = (mode_q == MODE_ALL) || key_hit;
    can_push  = !out_valid || res.ready;
    take      = (state == S_SCAN) && scan_more && hit && (rm != '0);
    emit_note = take && can_push;
    copy_we   = (state == S_SCAN) && scan_more && !take;
    scan_step = (state == S_SCAN) && scan_more && (!take || can_push);
    scan_done = (state == S_SCAN) && !scan_more;
    append_we = scan_done && (mode_q == MODE_ON) && !full_q;
    emit_drop = (state == S_DROP) && can_push;
    rest      = count - match_cnt;
    full_next = (mode_q == MODE_ON) && (rest == CNT_W'(PENDING_DEPTH));
    unique case (mode_q)
      MODE_ON:  rm_init = match_cnt;
      MODE_OFF: rm_init = (match_cnt != '0) ? CNT_W'(1) : '0;
      default:  rm_init = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      opened      <= '0;
      overlap     <= 1'b0;
      first_tick  <= '0;
      first_valid <= 1'b0;
      out_valid   <= 1'b0;
      idx         <= '0;
      wr          <= '0;
      match_cnt   <= '0;
      rm          <= '0;
      full_q      <= 1'b0;
    end else begin
      if (emit_note || emit_drop) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            idx       <= '0;
            match_cnt <= '0;
            if (evt.mode == MODE_ON || evt.mode == MODE_OFF || evt.mode == MODE_ALL) begin
              state <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          if (scan_more) begin
            if (key_hit) begin
              match_cnt <= match_cnt + CNT_W'(1);
            end
            idx <= idx + CNT_W'(1);
          end else begin
            rm     <= rm_init;
            full_q <= full_next;
            idx    <= '0;
            wr     <= '0;
            if (mode_q == MODE_ON) begin
              if (rest != '0) begin
                overlap <= 1'b1;
              end
              if (!full_next && !first_valid) begin
                first_tick  <= tick_q;
                first_valid <= 1'b1;
              end
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_step) begin
            idx <= idx + CNT_W'(1);
            if (take) begin
              rm <= rm - CNT_W'(1);
            end else begin
              wr <= wr + CNT_W'(1);
            end
          end
          if (scan_done) begin
            if (append_we) begin
              count  <= wr + CNT_W'(1);
              opened <= opened + NUM_W'(1);
              state  <= S_IDLE;
            end else begin
              count <= wr;
              state <= (mode_q == MODE_ON) ? S_DROP : S_IDLE;
            end
          end
        end
        S_DROP: begin
          if (can_push) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input capture, list storage and output word
  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      mode_q <= evt.mode;
      key_q  <= evt.key;
      vel_q  <= evt.velocity;
      tick_q <= evt.tick;
    end
    if (copy_we) begin
      pend[wr[IDX_W-1:0]] <= cur;
    end else if (append_we) begin
      pend[wr[IDX_W-1:0]] <= '{key: key_q, velocity: vel_q, start: tick_q, number: opened};
    end
    if (emit_note) begin
      o_kind    <= KIND_NOTE;
      o_number  <= cur.number;
      o_key     <= cur.key;
      o_vel     <= cur.velocity;
      o_start   <= cur.start;
      o_end     <= tick_q;
      o_last    <= rm == CNT_W'(1);
      o_poly    <= overlap;
      o_track   <= first_tick;
      o_started <= first_valid;
    end else if (emit_drop) begin
      o_kind    <= KIND_DROP;
      o_number  <= opened;
      o_key     <= key_q;
      o_vel     <= vel_q;
      o_start   <= tick_q;
      o_end     <= '0;
      o_last    <= 1'b1;
      o_poly    <= overlap;
      o_track   <= first_tick;
      o_started <= first_valid;
    end
  end

  assign evt.ready         = state == S_IDLE;
  assign res.valid         = out_valid;
  assign res.kind          = o_kind;
  assign res.note_number   = o_number;
  assign res.note_key      = o_key;
  assign res.note_velocity = o_vel;
  assign res.start_time    = o_start;
  assign res.end_time      = o_end;
  assign res.last          = o_last;
  assign res.polyphonic    = o_poly;
  assign res.track_start   = o_track;
  assign res.track_started = o_started;

endmodule

### tb/tb_top.sv
module tb_top;
  import mnpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int RANDOM_EVENTS = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
    logic [TICK_W-1:0] tick;
  } midi_event_t;

  typedef struct packed {
    logic              kind;
    logic [NUM_W-1:0]  number;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
    logic [TICK_W-1:0] start_time;
    logic [TICK_W-1:0] end_time;
    logic              last;
    logic              polyphonic;
    logic [TICK_W-1:0] track_start;
    logic              track_started;
  } note_word_t;

  logic clk = 1'b0;
  logic rst;
  logic hold;

  mnpt_evt_if  evt_bus ();
  mnpt_note_if res_bus ();

  midi_note_pairing_tracker_core u_top (
    .clk (clk),
    .rst (rst),
    .evt (evt_bus),
    .res (res_bus)
  );

  always #5 clk = ~clk;

  // tracker model state
  pend_entry_t      open_notes[$];
  logic [NUM_W-1:0] opened_total = '0;
  logic             overlap_seen = 1'b0;
  logic [TICK_W-1:0] first_tick = '0;
  logic             first_tick_valid = 1'b0;

  midi_event_t event_queue[$];
  midi_event_t on_bus;
  note_word_t  due_notes[$];
  note_word_t  got_note;

  int total_events = 0;
  int accepted = 0;
  int mismatches = 0;
  int notes_seen = 0;
  int drops_seen = 0;
  int tx_idle;
  int rx_idle;

  assign tx_idle = (accepted < total_events / 3) ? 25 :
                   (accepted < 2 * total_events / 3) ? 55 : 0;
  assign rx_idle = (accepted < total_events / 3) ? 55 :
                   (accepted < 2 * total_events / 3) ? 25 : 0;

  function automatic bit close_oldest(logic [KEY_W-1:0] k, logic [TICK_W-1:0] t,
                                      ref note_word_t batch[$]);
    note_word_t r;
    for (int i = 0; i < open_notes.size(); i++) begin
      if (open_notes[i].key == k) begin
        r = '0;
        r.kind = KIND_NOTE;
        r.number = open_notes[i].number;
        r.key = open_notes[i].key;
        r.velocity = open_notes[i].velocity;
        r.start_time = open_notes[i].start;
        r.end_time = t;
        batch.insert(batch.size(), r);
        open_notes.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void pair_notes(midi_event_t w);
    note_word_t  batch[$];
    note_word_t  r;
    pend_entry_t e;
    case (w.mode)
      MODE_ON: begin
        while (close_oldest(w.key, w.tick, batch)) ;
        if (open_notes.size() > 0) overlap_seen = 1'b1;
        if (open_notes.size() >= PENDING_DEPTH) begin
          r = '0;
          r.kind = KIND_DROP;
          r.number = opened_total;
          r.key = w.key;
          r.velocity = w.velocity;
          r.start_time = w.tick;
          r.end_time = '0;
          batch.insert(batch.size(), r);
        end else begin
          e.key = w.key;
          e.velocity = w.velocity;
          e.start = w.tick;
          e.number = opened_total;
          open_notes.insert(open_notes.size(), e);
          opened_total = opened_total + 1'b1;
          if (!first_tick_valid) begin
            first_tick = w.tick;
            first_tick_valid = 1'b1;
          end
        end
      end
      MODE_OFF: begin
        void'(close_oldest(w.key, w.tick, batch));
      end
      MODE_ALL: begin
        while (open_notes.size() > 0) void'(close_oldest(open_notes[0].key, w.tick, batch));
      end
      default: ;
    endcase
    for (int k = 0; k < batch.size(); k++) begin
      batch[k].last = (k == batch.size() - 1);
      batch[k].polyphonic = overlap_seen;
      batch[k].track_start = first_tick;
      batch[k].track_started = first_tick_valid;
      due_notes.insert(due_notes.size(), batch[k]);
    end
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_event(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                           logic [VEL_W-1:0] v, logic [TICK_W-1:0] t);
    midi_event_t w;
    w.mode = m;
    w.key = k;
    w.velocity = v;
    w.tick = t;
    event_queue.insert(event_queue.size(), w);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      evt_bus.valid <= 1'b0;
    end else begin
      if (evt_bus.valid && evt_bus.ready) begin
        pair_notes(on_bus);
        accepted++;
      end
      if (!evt_bus.valid || evt_bus.ready) begin
        if (event_queue.size() > 0 && $urandom_range(99) >= tx_idle) begin
          on_bus = event_queue.pop_front();
          evt_bus.valid <= 1'b1;
          evt_bus.mode <= on_bus.mode;
          evt_bus.key <= on_bus.key;
          evt_bus.velocity <= on_bus.velocity;
          evt_bus.tick <= on_bus.tick;
        end else begin
          evt_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (due_notes.size() == 0) begin
          $error("unexpected result word: key %0h number %0h",
                 res_bus.note_key, res_bus.note_number);
          mismatches++;
        end else begin
          got_note = due_notes.pop_front();
          if (got_note.kind == KIND_DROP) drops_seen++;
          else notes_seen++;
          cmp_field("kind", got_note.kind, res_bus.kind);
          cmp_field("note_number", got_note.number, res_bus.note_number);
          cmp_field("note_key", got_note.key, res_bus.note_key);
          cmp_field("note_velocity", got_note.velocity, res_bus.note_velocity);
          cmp_field("start_time", got_note.start_time, res_bus.start_time);
          cmp_field("end_time", got_note.end_time, res_bus.end_time);
          cmp_field("last", got_note.last, res_bus.last);
          cmp_field("polyphonic", got_note.polyphonic, res_bus.polyphonic);
          cmp_field("track_start", got_note.track_start, res_bus.track_start);
          cmp_field("track_started", got_note.track_started, res_bus.track_started);
        end
      end
      res_bus.ready <= !hold && ($urandom_range(99) >= rx_idle);
    end
  end

  // long receiver stall so the list and output back up
  initial begin
    hold = 1'b0;
    @(posedge clk);
    while (accepted < 150) @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [TICK_W-1:0] t;
    logic [KEY_W-1:0]  k;
    logic [MODE_W-1:0] m;
    int made;
    int run_len;
    int r;
    bit filling;

    rst = 1'b1;
    evt_bus.valid = 1'b0;
    evt_bus.mode = MODE_ON;
    evt_bus.key = '0;
    evt_bus.velocity = '0;
    evt_bus.tick = '0;
    res_bus.ready = 1'b0;

    // directed: extremes, same-key reopen, unmatched close, ignored mode, empty flush
    add_event(MODE_ON, 7'd0, 7'd0, 32'h0000_0000);
    add_event(MODE_ON, 7'd127, 7'd127, 32'hFFFF_FFFF);
    add_event(MODE_ON, 7'd127, 7'd5, 32'h0000_0100);
    add_event(MODE_OFF, 7'd0, 7'd127, 32'h0000_0200);
    add_event(MODE_OFF, 7'd55, 7'd0, 32'h0000_0300);
    add_event(MODE_NONE, 7'd127, 7'd127, 32'hFFFF_FFFF);
    add_event(MODE_ALL, 7'd0, 7'd0, 32'h8000_0000);
    add_event(MODE_ALL, 7'd127, 7'd0, 32'h8000_0001);
    // fill the list, overflow it, then reopen a pending key while full
    for (int i = 1; i <= PENDING_DEPTH; i++)
      add_event(MODE_ON, KEY_W'(i), VEL_W'(i * 7), TICK_W'(1000 + i));
    add_event(MODE_ON, 7'd100, 7'd64, 32'h0000_2000);
    add_event(MODE_ON, 7'd3, 7'd99, 32'h0000_2001);
    add_event(MODE_ALL, 7'd0, 7'd0, 32'h0000_3000);

    // random runs: filling runs mostly open, draining runs mostly close
    t = 32'h0001_0000;
    made = 0;
    while (made < RANDOM_EVENTS) begin
      run_len = $urandom_range(5, 25);
      filling = 1'($urandom_range(1));
      for (int i = 0; i < run_len; i++) begin
        r = $urandom_range(99);
        if (filling)
          m = (r < 78) ? MODE_ON : (r < 94) ? MODE_OFF : (r < 97) ? MODE_ALL : MODE_NONE;
        else
          m = (r < 25) ? MODE_ON : (r < 90) ? MODE_OFF : (r < 96) ? MODE_ALL : MODE_NONE;
        k = ($urandom_range(99) < 80) ? KEY_W'($urandom_range(32, 63))
                                      : KEY_W'($urandom_range(0, 127));
        if ($urandom_range(99) < 10) t = $urandom;
        else t = t + $urandom_range(0, 500);
        add_event(m, k, VEL_W'($urandom_range(0, 127)), t);
        if (m != MODE_NONE) made++;
      end
      if ($urandom_range(99) < 30) begin
        t = t + $urandom_range(0, 500);
        add_event(MODE_ALL, KEY_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)), t);
        made++;
      end
    end
    total_events = event_queue.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted < total_events) @(posedge clk);
    while (due_notes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_notes.size() > 0) begin
      $error("%0d result words never arrived", due_notes.size());
      mismatches += due_notes.size();
    end

    $display("Run: %0d event words sent, %0d finished notes and %0d dropped opens checked",
             total_events, notes_seen, drops_seen);
    $display("Overlap flag seen: %0d, notes opened: %0d", overlap_seen, opened_total);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### midi_note_pairing_tracker_core.f
rtl/mnpt_pkg.sv
rtl/mnpt_evt_if.sv
rtl/mnpt_note_if.sv
rtl/midi_note_pairing_tracker_core.sv
tb/tb_top.sv
